// ===== src/hdrg_pkg.sv =====
// ----------------------------------------------------------------------------
// hdrg_pkg: H-bridge drive with reversal guard, shared definitions
// Sequencer states, direction codes, divider control, register indexes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package hdrg_pkg;

  localparam int DUTY_W = 15;
  localparam int OUT_DUTY_W = 14;
  localparam int CNT_W = 32;
  localparam int CPR_W = 24;
  localparam int WRAP_W = 16;
  localparam int CONT_W = 48;
  localparam int TURN_W = 16;
  localparam int STEP_W = 5;

  localparam logic signed [DUTY_W-1:0] DUTY_MAX = 15'sd9900;
  localparam logic signed [DUTY_W-1:0] DUTY_DEAD = 15'sd100;
  localparam logic [TURN_W-1:0] FULL_TURN = 16'd36000;
  localparam logic [TURN_W:0] FULL_TURN_X = 17'd36000;
  localparam logic [TURN_W:0] HALF_TURN_X = 17'd18000;

  // divider passes: full magnitude quotient, then a quotient known to be below 2^16
  localparam logic [STEP_W-1:0] DIV1_LAST = 5'd31;
  localparam logic [STEP_W-1:0] DIV2_LAST = 5'd15;

  localparam logic [1:0] CFG_REVERSE = 2'd0;
  localparam logic [1:0] CFG_PERIOD = 2'd1;
  localparam logic [1:0] CFG_CPR = 2'd2;
  localparam logic [1:0] CFG_PROTECT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL,
    ST_DIV1,
    ST_MUL1,
    ST_DIV2,
    ST_MUL2,
    ST_FIN,
    ST_DONE
  } hdrg_state_t;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_POS,
    DIR_NEG
  } hdrg_dir_t;

  typedef struct packed {
    logic load;
    logic step;
  } hdrg_div_ctl_t;

endpackage

`default_nettype wire

// ===== src/hdrg_div.sv =====
// ----------------------------------------------------------------------------
// hdrg_div: shared restoring divider
// One quotient bit per step; remainder stays below the 24-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module hdrg_div (
  input  wire logic                        clk,
  input  wire hdrg_pkg::hdrg_div_ctl_t     ctl,
  input  wire logic [hdrg_pkg::CPR_W-1:0]  divisor,
  input  wire logic [hdrg_pkg::CPR_W-1:0]  rem_init,
  input  wire logic [hdrg_pkg::CNT_W-1:0]  dvd_init,
  output logic      [hdrg_pkg::CPR_W-1:0]  rem,
  output logic      [hdrg_pkg::CNT_W-1:0]  dvd
);
  import hdrg_pkg::*;

  logic [CPR_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] dvd_r, dvd_nxt;
  logic [CPR_W:0]   shifted;
  logic [CPR_W:0]   diff;
  logic             fits;

  // dividend bits leave at the top of dvd_r, quotient bits enter at the bottom
  always_comb begin
    shifted = {rem_r, dvd_r[CNT_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    if (ctl.load) begin
      rem_nxt = rem_init;
      dvd_nxt = dvd_init;
    end else if (ctl.step) begin
      rem_nxt = fits ? diff[CPR_W-1:0] : shifted[CPR_W-1:0];
      dvd_nxt = {dvd_r[CNT_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign rem = rem_r;
  assign dvd = dvd_r;

endmodule

`default_nettype wire

// ===== src/hbridge_drive_with_reversal_guard_top.sv =====
// ----------------------------------------------------------------------------
// hbridge_drive_with_reversal_guard_top: H-bridge drive with reversal guard
// Duty shaping, reversal dead time and encoder shaft angle tracking.
// ----------------------------------------------------------------------------
// Flow: an accepted tick without an angle recompute, or with a zero latch, goes
//   straight to ST_DONE; a recompute tick first passes REL, DIV1, MUL1, DIV2, MUL2, FIN.
// The input stalls until ST_DONE hands the result to the output register; the
//   recompute runs a 32-step and a 16-step pass through one shared restoring divider.
// Reset (rst_n low, synchronous): registers to their defaults, guard idle,
//   angles zero, zero latch armed; no output transaction pending.
`default_nettype none

module hbridge_drive_with_reversal_guard_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // configuration
  input  wire logic                                  cfg_we,
  input  wire logic [1:0]                            cfg_index,
  input  wire logic [hdrg_pkg::CPR_W-1:0]            cfg_wdata,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [hdrg_pkg::DUTY_W-1:0]    in_target_duty,
  input  wire logic                                  in_no_force,
  input  wire logic signed [hdrg_pkg::CNT_W-1:0]     in_encoder_count,
  input  wire logic                                  in_zero_request,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_drive_enable,
  output logic [hdrg_pkg::OUT_DUTY_W-1:0]            out_duty_a,
  output logic [hdrg_pkg::OUT_DUTY_W-1:0]            out_duty_b,
  output logic                                       out_reversing,
  output logic signed [hdrg_pkg::WRAP_W-1:0]         out_angle_wrapped,
  output logic signed [hdrg_pkg::CONT_W-1:0]         out_angle_continuous
);
  import hdrg_pkg::*;

  // configuration
  logic              rev_motor_r, rev_motor_nxt;
  logic [15:0]       period_r, period_nxt;
  logic [CPR_W-1:0]  cpr_r, cpr_nxt;
  logic [7:0]        protect_r, protect_nxt;

  // control and architectural state
  hdrg_state_t       state_r, state_nxt;
  logic              guard_r, guard_nxt;
  hdrg_dir_t         dir_r, dir_nxt;
  logic [7:0]        gcnt_r, gcnt_nxt;
  logic [15:0]       udiv_r, udiv_nxt;
  logic signed [CNT_W-1:0]  zcnt_r, zcnt_nxt;
  logic              zpend_r, zpend_nxt;
  logic signed [WRAP_W-1:0] wrap_r, wrap_nxt;
  logic signed [CONT_W-1:0] cont_r, cont_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  // per-transaction working registers
  logic              en_r, en_nxt;
  logic [OUT_DUTY_W-1:0] da_r, da_nxt, db_r, db_nxt;
  logic              rev_r, rev_nxt;
  logic signed [CNT_W-1:0] count_r, count_nxt;
  logic              neg_r, neg_nxt;
  logic              r1nz_r, r1nz_nxt;
  logic [CNT_W-1:0]  q1_r, q1_nxt;
  logic [CONT_W-1:0] prod_r, prod_nxt;

  // output register
  logic              out_en_r, out_en_nxt;
  logic [OUT_DUTY_W-1:0] out_da_r, out_da_nxt, out_db_r, out_db_nxt;
  logic              out_rev_r, out_rev_nxt;
  logic signed [WRAP_W-1:0] out_wrap_r, out_wrap_nxt;
  logic signed [CONT_W-1:0] out_cont_r, out_cont_nxt;

  // combinational
  logic              accept;
  logic signed [DUTY_W-1:0] duty_c;
  hdrg_dir_t         dir_c;
  logic [15:0]       udiv_inc;
  logic              upd_c;
  logic              pend_c;
  logic [CNT_W:0]    rel_c;
  logic [CNT_W:0]    rel_abs;
  logic [CPR_W-1:0]  cpr_eff;
  logic [CNT_W-1:0]  mul_a;
  logic [CONT_W-1:0] mul_out;
  logic [CONT_W-1:0] mag_c;
  logic [TURN_W:0]   part_c;
  logic [TURN_W:0]   wrap_c;
  logic              out_load;

  hdrg_div_ctl_t     div_ctl;
  logic [CPR_W-1:0]  div_rem_init;
  logic [CNT_W-1:0]  div_dvd_init;
  logic [CPR_W-1:0]  div_rem;
  logic [CNT_W-1:0]  div_dvd;

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || !rst_n;
  assign cpr_eff = (cpr_r == '0) ? CPR_W'(1) : cpr_r;

  hdrg_div u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .divisor  (cpr_eff),
    .rem_init (div_rem_init),
    .dvd_init (div_dvd_init),
    .rem      (div_rem),
    .dvd      (div_dvd)
  );

  // single shared constant multiplier: remainder scaling, then quotient scaling
  assign mul_a   = (state_r == ST_MUL2) ? q1_r : {{(CNT_W-CPR_W){1'b0}}, div_rem};
  assign mul_out = CONT_W'(mul_a) * CONT_W'(FULL_TURN);

  // duty shaping
  always_comb begin
    duty_c = in_target_duty;
    if (duty_c > DUTY_MAX) begin
      duty_c = DUTY_MAX;
    end
    if (duty_c < -DUTY_MAX) begin
      duty_c = -DUTY_MAX;
    end
    if ((duty_c > -DUTY_DEAD) && (duty_c < DUTY_DEAD)) begin
      duty_c = '0;
    end
    if (rev_motor_r) begin
      duty_c = -duty_c;
    end
    if (duty_c > 0) begin
      dir_c = DIR_POS;
    end else if (duty_c < 0) begin
      dir_c = DIR_NEG;
    end else begin
      dir_c = DIR_NONE;
    end
  end

  always_comb begin
    udiv_inc = udiv_r + 16'd1;
    upd_c    = (udiv_inc >= period_r);
    pend_c   = zpend_r || in_zero_request;
    rel_c    = {count_r[CNT_W-1], count_r} - {zcnt_r[CNT_W-1], zcnt_r};
    rel_abs  = rel_c[CNT_W] ? -rel_c : rel_c;
    // floor(|rel| * 36000 / cpr) = q1 * 36000 + floor(r1 * 36000 / cpr)
    mag_c    = prod_r + CONT_W'(div_dvd[TURN_W-1:0]);
    if (neg_r && r1nz_r) begin
      part_c = FULL_TURN_X - {1'b0, div_dvd[TURN_W-1:0]} - {{TURN_W{1'b0}}, (div_rem != '0)};
    end else begin
      part_c = {1'b0, div_dvd[TURN_W-1:0]};
    end
    wrap_c   = (part_c >= HALF_TURN_X) ? (part_c - FULL_TURN_X) : part_c;
    out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  // configuration writes
  always_comb begin
    rev_motor_nxt = rev_motor_r;
    period_nxt    = period_r;
    cpr_nxt       = cpr_r;
    protect_nxt   = protect_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_REVERSE: rev_motor_nxt = cfg_wdata[0];
        CFG_PERIOD:  period_nxt    = cfg_wdata[15:0];
        CFG_CPR:     cpr_nxt       = cfg_wdata;
        CFG_PROTECT: protect_nxt   = cfg_wdata[7:0];
        default:     rev_motor_nxt = rev_motor_r;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    guard_nxt    = guard_r;
    dir_nxt      = dir_r;
    gcnt_nxt     = gcnt_r;
    udiv_nxt     = udiv_r;
    zcnt_nxt     = zcnt_r;
    zpend_nxt    = zpend_r;
    wrap_nxt     = wrap_r;
    cont_nxt     = cont_r;
    step_nxt     = step_r;
    en_nxt       = en_r;
    da_nxt       = da_r;
    db_nxt       = db_r;
    rev_nxt      = rev_r;
    count_nxt    = count_r;
    neg_nxt      = neg_r;
    r1nz_nxt     = r1nz_r;
    q1_nxt       = q1_r;
    prod_nxt     = prod_r;
    div_ctl      = '0;
    div_rem_init = '0;
    div_dvd_init = rel_abs[CNT_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          count_nxt = in_encoder_count;
          en_nxt    = 1'b0;
          da_nxt    = '0;
          db_nxt    = '0;
          rev_nxt   = 1'b0;

          if (in_zero_request) begin
            wrap_nxt  = '0;
            cont_nxt  = '0;
            zpend_nxt = 1'b1;
          end
          state_nxt = ST_DONE;
          udiv_nxt  = udiv_inc;
          if (upd_c) begin
            udiv_nxt = '0;
            if (pend_c) begin
              zcnt_nxt  = in_encoder_count;
              wrap_nxt  = '0;
              cont_nxt  = '0;
              zpend_nxt = 1'b0;
            end else begin
              state_nxt = ST_REL;
            end
          end

          // bridge and reversal guard
          if (in_no_force) begin
            guard_nxt = 1'b0;
            dir_nxt   = DIR_NONE;
          end else if (!guard_r) begin
            if ((dir_r != DIR_NONE) && (dir_c != DIR_NONE) && (dir_r != dir_c)) begin
              guard_nxt = 1'b1;
              gcnt_nxt  = '0;
              rev_nxt   = 1'b1;
            end else if (dir_c == DIR_POS) begin
              en_nxt  = 1'b1;
              da_nxt  = duty_c[OUT_DUTY_W-1:0];
              dir_nxt = DIR_POS;
            end else if (dir_c == DIR_NEG) begin
              en_nxt  = 1'b1;
              db_nxt  = OUT_DUTY_W'(-duty_c);
              dir_nxt = DIR_NEG;
            end
          end else begin
            rev_nxt  = 1'b1;
            gcnt_nxt = (gcnt_r == 8'hFF) ? gcnt_r : (gcnt_r + 8'd1);
            if (gcnt_nxt >= protect_r) begin
              guard_nxt = 1'b0;
              dir_nxt   = DIR_NONE;
            end
          end
        end
      end
      ST_REL: begin
        neg_nxt      = rel_c[CNT_W];
        div_ctl.load = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV1;
      end
      ST_DIV1: begin
        div_ctl.step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == DIV1_LAST) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        // r1 * 36000 < cpr * 2^16, so its top bits are already a valid remainder
        q1_nxt       = div_dvd;
        r1nz_nxt     = (div_rem != '0);
        div_ctl.load = 1'b1;
        div_rem_init = mul_out[TURN_W+CPR_W-1:TURN_W];
        div_dvd_init = {mul_out[TURN_W-1:0], {(CNT_W-TURN_W){1'b0}}};
        step_nxt     = '0;
        state_nxt    = ST_DIV2;
      end
      ST_DIV2: begin
        div_ctl.step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == DIV2_LAST) begin
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        prod_nxt  = mul_out;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!neg_r) begin
          cont_nxt = mag_c[CONT_W-1] ? {1'b0, {(CONT_W-1){1'b1}}} : mag_c;
        end else begin
          cont_nxt = (mag_c[CONT_W-1] && (mag_c[CONT_W-2:0] != '0)) ?
                     {1'b1, {(CONT_W-1){1'b0}}} : -mag_c;
        end
        wrap_nxt  = wrap_c[WRAP_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_en_nxt    = out_en_r;
    out_da_nxt    = out_da_r;
    out_db_nxt    = out_db_r;
    out_rev_nxt   = out_rev_r;
    out_wrap_nxt  = out_wrap_r;
    out_cont_nxt  = out_cont_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_en_nxt    = en_r;
      out_da_nxt    = da_r;
      out_db_nxt    = db_r;
      out_rev_nxt   = rev_r;
      out_wrap_nxt  = wrap_r;
      out_cont_nxt  = cont_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_motor_r <= 1'b0;
      period_r    <= 16'd1;
      cpr_r       <= 24'd4096;
      protect_r   <= 8'd2;
      state_r     <= ST_IDLE;
      guard_r     <= 1'b0;
      dir_r       <= DIR_NONE;
      gcnt_r      <= '0;
      udiv_r      <= '0;
      zcnt_r      <= '0;
      zpend_r     <= 1'b1;
      wrap_r      <= '0;
      cont_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rev_motor_r <= rev_motor_nxt;
      period_r    <= period_nxt;
      cpr_r       <= cpr_nxt;
      protect_r   <= protect_nxt;
      state_r     <= state_nxt;
      guard_r     <= guard_nxt;
      dir_r       <= dir_nxt;
      gcnt_r      <= gcnt_nxt;
      udiv_r      <= udiv_nxt;
      zcnt_r      <= zcnt_nxt;
      zpend_r     <= zpend_nxt;
      wrap_r      <= wrap_nxt;
      cont_r      <= cont_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    en_r       <= en_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    rev_r      <= rev_nxt;
    count_r    <= count_nxt;
    neg_r      <= neg_nxt;
    r1nz_r     <= r1nz_nxt;
    q1_r       <= q1_nxt;
    prod_r     <= prod_nxt;
    out_en_r   <= out_en_nxt;
    out_da_r   <= out_da_nxt;
    out_db_r   <= out_db_nxt;
    out_rev_r  <= out_rev_nxt;
    out_wrap_r <= out_wrap_nxt;
    out_cont_r <= out_cont_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_drive_enable     = out_en_r;
  assign out_duty_a           = out_da_r;
  assign out_duty_b           = out_db_r;
  assign out_reversing        = out_rev_r;
  assign out_angle_wrapped    = out_wrap_r;
  assign out_angle_continuous = out_cont_r;

  // a guard interval always follows a known direction
  assert property (@(posedge clk) disable iff (!rst_n)
    guard_r |-> (dir_r != DIR_NONE))
    else $error("guard active with no recorded direction");

  // never drive both half-bridges, never drive during a reversal
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_duty_a == '0) || (out_duty_b == '0)) && !(out_drive_enable && out_reversing))
    else $error("conflicting bridge drive");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_wrapped >= -16'sd18000) && (out_angle_wrapped <= 16'sd17999))
    else $error("wrapped angle out of range");

  // a finished transaction cannot be overwritten while the output is held
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_angle_continuous)))
    else $error("held result changed");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: H-bridge drive with reversal guard
// Walks a short table of directed ticks, then runs random ticks under several
// register settings. Table rows that carry an expected result are checked against
// it; every other result against a cycle-free model of the duty shaping, reversal
// guard and encoder angle tracking. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module testbench;
  import hdrg_pkg::*;

  typedef struct packed {
    logic signed [DUTY_W-1:0] duty;
    logic                     coast;
    logic signed [CNT_W-1:0]  count;
    logic                     zero_req;
  } tick_in_t;

  typedef struct packed {
    logic                      en;
    logic [OUT_DUTY_W-1:0]     da;
    logic [OUT_DUTY_W-1:0]     db;
    logic                      rev;
    logic signed [WRAP_W-1:0]  wrap;
    logic signed [CONT_W-1:0]  cont;
  } bridge_out_t;

  typedef struct packed {
    tick_in_t    stim;
    logic        typed;
    bridge_out_t want;
  } script_row_t;

  localparam bridge_out_t IDLE_OUT = '0;
  localparam longint CONT_TOP = 64'sd140737488355327;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASES = 8;
  localparam int PHASE_TICKS = 55;

  // reset settings: reverse 0, period 1, 4096 counts per turn, guard 2 ticks
  localparam script_row_t SCRIPT [24] = '{
    '{'{15'sd0, 1'b0, 32'sd0, 1'b0}, 1'b1, '{1'b0, 14'd0, 14'd0, 1'b0, 16'sd0, 48'sd0}},
    '{'{15'sd10000, 1'b0, 32'sd0, 1'b0}, 1'b1,
      '{1'b1, 14'd9900, 14'd0, 1'b0, 16'sd0, 48'sd0}},
    '{'{15'sd9900, 1'b0, 32'sd1024, 1'b0}, 1'b1,
      '{1'b1, 14'd9900, 14'd0, 1'b0, 16'sd9000, 48'sd9000}},
    // half turn wraps to the negative end
    '{'{15'sd50, 1'b0, 32'sd2048, 1'b0}, 1'b1,
      '{1'b0, 14'd0, 14'd0, 1'b0, -16'sd18000, 48'sd18000}},
    // reversal starts the guard
    '{'{-15'sd10000, 1'b0, 32'sd4096, 1'b0}, 1'b1,
      '{1'b0, 14'd0, 14'd0, 1'b1, 16'sd0, 48'sd36000}},
    '{'{-15'sd5000, 1'b0, -32'sd1, 1'b0}, 1'b1,
      '{1'b0, 14'd0, 14'd0, 1'b1, -16'sd9, -48'sd8}},
    '{'{-15'sd5000, 1'b0, 32'sd0, 1'b0}, 1'b1, '{1'b0, 14'd0, 14'd0, 1'b1, 16'sd0, 48'sd0}},
    '{'{-15'sd5000, 1'b0, 32'sd0, 1'b0}, 1'b1,
      '{1'b1, 14'd0, 14'd5000, 1'b0, 16'sd0, 48'sd0}},
    '{'{15'sd9900, 1'b1, 32'sd0, 1'b0}, 1'b1, '{1'b0, 14'd0, 14'd0, 1'b0, 16'sd0, 48'sd0}},
    '{'{15'sd100, 1'b0, 32'sd0, 1'b0}, 1'b1, '{1'b1, 14'd100, 14'd0, 1'b0, 16'sd0, 48'sd0}},
    '{'{-15'sd100, 1'b0, 32'sd0, 1'b0}, 1'b1, '{1'b0, 14'd0, 14'd0, 1'b1, 16'sd0, 48'sd0}},
    // coast cancels the guard
    '{'{-15'sd100, 1'b1, 32'sd0, 1'b0}, 1'b1, '{1'b0, 14'd0, 14'd0, 1'b0, 16'sd0, 48'sd0}},
    '{'{-15'sd99, 1'b0, 32'sd0, 1'b0}, 1'b1, '{1'b0, 14'd0, 14'd0, 1'b0, 16'sd0, 48'sd0}},
    '{'{15'h4000, 1'b0, 32'sd0, 1'b0}, 1'b1, '{1'b1, 14'd0, 14'd9900, 1'b0, 16'sd0, 48'sd0}},
    '{'{15'h3FFF, 1'b0, 32'sd0, 1'b0}, 1'b1, '{1'b0, 14'd0, 14'd0, 1'b1, 16'sd0, 48'sd0}},
    '{'{15'h3FFF, 1'b0, 32'sd0, 1'b0}, 1'b1, '{1'b0, 14'd0, 14'd0, 1'b1, 16'sd0, 48'sd0}},
    '{'{15'sd0, 1'b0, 32'sd0, 1'b0}, 1'b1, '{1'b0, 14'd0, 14'd0, 1'b1, 16'sd0, 48'sd0}},
    '{'{15'sd0, 1'b0, 32'sd0, 1'b0}, 1'b1, '{1'b0, 14'd0, 14'd0, 1'b0, 16'sd0, 48'sd0}},
    '{'{15'sd2000, 1'b0, 32'sd12345, 1'b1}, 1'b0, IDLE_OUT},
    '{'{15'sd2000, 1'b0, 32'sh7FFFFFFF, 1'b0}, 1'b0, IDLE_OUT},
    '{'{15'sd2000, 1'b0, 32'sh80000000, 1'b0}, 1'b0, IDLE_OUT},
    '{'{-15'sd1, 1'b0, 32'sh55555555, 1'b0}, 1'b0, IDLE_OUT},
    '{'{15'h2AAA, 1'b0, 32'shAAAAAAAA, 1'b0}, 1'b0, IDLE_OUT},
    '{'{15'h5555, 1'b0, 32'sd0, 1'b1}, 1'b0, IDLE_OUT}
  };

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_index = CFG_REVERSE;
  logic [CPR_W-1:0]          cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [DUTY_W-1:0]  in_target_duty = '0;
  logic                      in_no_force = 1'b0;
  logic signed [CNT_W-1:0]   in_encoder_count = '0;
  logic                      in_zero_request = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_drive_enable;
  logic [OUT_DUTY_W-1:0]     out_duty_a;
  logic [OUT_DUTY_W-1:0]     out_duty_b;
  logic                      out_reversing;
  logic signed [WRAP_W-1:0]  out_angle_wrapped;
  logic signed [CONT_W-1:0]  out_angle_continuous;

  hbridge_drive_with_reversal_guard_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_target_duty       (in_target_duty),
    .in_no_force          (in_no_force),
    .in_encoder_count     (in_encoder_count),
    .in_zero_request      (in_zero_request),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_drive_enable     (out_drive_enable),
    .out_duty_a           (out_duty_a),
    .out_duty_b           (out_duty_b),
    .out_reversing        (out_reversing),
    .out_angle_wrapped    (out_angle_wrapped),
    .out_angle_continuous (out_angle_continuous)
  );

  // register shadows
  logic                      rev_motor = 1'b0;
  logic [15:0]               upd_period = 16'd1;
  logic [CPR_W-1:0]          cpr = 24'd4096;
  logic [7:0]                protect = 8'd2;

  // bridge and angle state
  logic                      guard_on = 1'b0;
  hdrg_dir_t                 last_dir = DIR_NONE;
  int unsigned               guard_cnt = 0;
  logic [15:0]               div_cnt = '0;
  longint                    zero_cnt = 0;
  logic                      zero_arm = 1'b1;
  logic signed [WRAP_W-1:0]  wrap_ang = '0;
  logic signed [CONT_W-1:0]  cont_ang = '0;

  bridge_out_t               owed_outputs [$];
  int                        err_count = 0;
  int                        outs_seen = 0;
  int                        quiet = 0;
  logic                      no_idle = 1'b0;
  int                        run_sign = 1;
  int                        enc_pos = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bridge_out_t bridge_tick_outcome(tick_in_t t);
    int        duty;
    int        dmax;
    int        dead;
    longint    cnt;
    longint    span;
    longint    rel;
    longint    ang;
    longint    part;
    longint    turn;
    longint    half;
    hdrg_dir_t heading;
    bridge_out_t o;
    o = '0;
    dmax = DUTY_MAX;
    dead = DUTY_DEAD;
    turn = FULL_TURN;
    half = HALF_TURN_X;
    duty = t.duty;
    cnt = t.count;
    if (duty > dmax) duty = dmax;
    if (duty < -dmax) duty = -dmax;
    if (duty > -dead && duty < dead) duty = 0;
    if (rev_motor) duty = -duty;

    if (t.coast) begin
      guard_on = 1'b0;
      last_dir = DIR_NONE;
    end
    if (t.zero_req) begin
      wrap_ang = '0;
      cont_ang = '0;
      zero_arm = 1'b1;
    end

    div_cnt = div_cnt + 16'd1;
    if (div_cnt >= upd_period) begin
      div_cnt = '0;
      if (zero_arm) begin
        zero_cnt = cnt;
        wrap_ang = '0;
        cont_ang = '0;
        zero_arm = 1'b0;
      end else begin
        span = (cpr == '0) ? 64'sd1 : longint'(cpr);
        rel = cnt - zero_cnt;
        ang = rel * turn / span;
        if (ang > CONT_TOP) ang = CONT_TOP;
        if (ang < -CONT_TOP - 1) ang = -CONT_TOP - 1;
        cont_ang = ang[CONT_W-1:0];
        part = rel % span;
        if (part < 0) part += span;
        part = part * turn / span;
        if (part >= half) part -= turn;
        wrap_ang = part[WRAP_W-1:0];
      end
    end

    if (!t.coast) begin
      heading = (duty > 0) ? DIR_POS : ((duty < 0) ? DIR_NEG : DIR_NONE);
      if (!guard_on) begin
        if (last_dir != DIR_NONE && heading != DIR_NONE && last_dir != heading) begin
          guard_on = 1'b1;
          guard_cnt = 0;
          o.rev = 1'b1;
        end else if (heading == DIR_POS) begin
          o.en = 1'b1;
          o.da = OUT_DUTY_W'(duty);
          last_dir = DIR_POS;
        end else if (heading == DIR_NEG) begin
          o.en = 1'b1;
          o.db = OUT_DUTY_W'(-duty);
          last_dir = DIR_NEG;
        end
      end else begin
        o.rev = 1'b1;
        if (guard_cnt < 255) guard_cnt++;
        if (guard_cnt >= protect) begin
          guard_on = 1'b0;
          last_dir = DIR_NONE;
        end
      end
    end
    o.wrap = wrap_ang;
    o.cont = cont_ang;
    return o;
  endfunction

  task automatic log_mismatch(string field, longint got, longint want);
    $display("result %0d: %s got %0d, want %0d", outs_seen, field, got, want);
    err_count++;
  endtask

  task automatic send_tick(tick_in_t t, logic typed, bridge_out_t want);
    int gap;
    bridge_out_t calc;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_duty <= t.duty;
    in_no_force <= t.coast;
    in_encoder_count <= t.count;
    in_zero_request <= t.zero_req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calc = bridge_tick_outcome(t);
    owed_outputs.push_back(typed ? want : calc);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [CPR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_REVERSE: rev_motor = val[0];
      CFG_PERIOD:  upd_period = val[15:0];
      CFG_CPR:     cpr = val;
      CFG_PROTECT: protect = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic r, logic [15:0] p, logic [CPR_W-1:0] c, logic [7:0] g);
    put_reg(CFG_REVERSE, CPR_W'(r));
    put_reg(CFG_PERIOD, CPR_W'(p));
    put_reg(CFG_CPR, c);
    put_reg(CFG_PROTECT, CPR_W'(g));
    cfg_we <= 1'b0;
  endtask

  // waits out every owed result plus the longest recompute
  task automatic settle();
    in_valid <= 1'b0;
    while (owed_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic make_tick(output tick_in_t t);
    int pick;
    int mag;
    int wild;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      t.duty = DUTY_W'($urandom);
    end else begin
      // mostly runs of one direction with occasional reversals
      if ($urandom_range(0, 7) == 0) run_sign = -run_sign;
      pick = $urandom_range(0, 99);
      if (pick < 70) mag = $urandom_range(100, 10000);
      else if (pick < 85) mag = $urandom_range(0, 120);
      else mag = $urandom_range(9890, 10000);
      t.duty = DUTY_W'(run_sign * mag);
    end
    t.coast = ($urandom_range(0, 11) == 0);
    t.zero_req = ($urandom_range(0, 24) == 0);
    // tiny counts per turn push the continuous angle toward saturation
    wild = (cpr <= 2) ? 30 : 10;
    pick = $urandom_range(0, 99);
    if (pick < wild) begin
      enc_pos = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      if ($urandom_range(0, 1) == 1) t.zero_req = 1'b1;
    end else if (pick < wild + 8) begin
      enc_pos = $urandom;
    end else begin
      enc_pos = enc_pos + $urandom_range(0, 4000) - 2000;
    end
    t.count = enc_pos;
  endtask

  initial begin
    tick_in_t t;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < $size(SCRIPT); i++)
      send_tick(SCRIPT[i].stim, SCRIPT[i].typed, SCRIPT[i].want);
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: set_regs(1'b0, 16'd1, 24'd1, 8'd0);
        1: set_regs(1'b1, 16'd0, 24'd0, 8'd1);
        2: set_regs(1'b0, 16'd3, 24'hFFFFFF, 8'd255);
        3: set_regs(1'b1, 16'hFFFF, 24'd4096, 8'd2);
        4: set_regs(1'b0, 16'd1, 24'd3, 8'd5);
        6: set_regs(1'b1, 16'd2, 24'd360, 8'd3);
        default: set_regs(1'($urandom_range(0, 1)), 16'($urandom_range(0, 8)),
                          CPR_W'($urandom_range(1, 24'hFFFFFF)),
                          8'($urandom_range(0, 12)));
      endcase
      no_idle = (ph % 3 == 2);
      for (int k = 0; k < PHASE_TICKS; k++) begin
        make_tick(t);
        send_tick(t, 1'b0, IDLE_OUT);
      end
    end
    settle();
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stall before each transaction, then compare
  initial begin
    int hold;
    bridge_out_t got;
    bridge_out_t want;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!rst_n || out_valid !== 1'b1) @(posedge clk);
      got = '{out_drive_enable, out_duty_a, out_duty_b, out_reversing,
              out_angle_wrapped, out_angle_continuous};
      if (owed_outputs.size() == 0) begin
        log_mismatch("unexpected transaction, drive_enable", got.en, 0);
      end else begin
        want = owed_outputs.pop_front();
        if (got.en !== want.en) log_mismatch("drive_enable", got.en, want.en);
        if (got.da !== want.da) log_mismatch("duty_a", got.da, want.da);
        if (got.db !== want.db) log_mismatch("duty_b", got.db, want.db);
        if (got.rev !== want.rev) log_mismatch("reversing", got.rev, want.rev);
        if (got.wrap !== want.wrap) log_mismatch("angle_wrapped", got.wrap, want.wrap);
        if (got.cont !== want.cont) log_mismatch("angle_continuous", got.cont, want.cont);
      end
      outs_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
